// File: rtl/ztl_pkg.sv
// Package with shared types and constants of the zone toggle link controller.
package ztl_pkg;

    localparam int ZONES      = 5;
    localparam int REPLY_LEN  = 9;
    localparam int TABLE_ROWS = 20;

    // Channel commands.
    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_RX    = 2'd1,
        CMD_ZONE  = 2'd2,
        CMD_TICK  = 2'd3
    } cmd_t;

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_TX      = 2'd0,
        KIND_MASK    = 2'd1,
        KIND_CONFIRM = 2'd2
    } kind_t;

    // Configuration register indexes.
    localparam logic [2:0] REG_PREFIX  = 3'd0;
    localparam logic [2:0] REG_CODES   = 3'd1;
    localparam logic [2:0] REG_START   = 3'd2;
    localparam logic [2:0] REG_SAVED   = 3'd3;
    localparam logic [2:0] REG_TIMEOUT = 3'd4;
    localparam logic [2:0] REG_RETRY   = 3'd5;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] rx_byte;
        logic [2:0] zone;
        logic       want_on;
    } in_beat_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] tx_byte;
        logic [4:0] active_zones;
        logic [2:0] confirm_zone;
        logic       confirm_on;
        logic       last;
    } out_beat_t;

    typedef struct packed {
        logic       known;
        logic [4:0] mask;
    } match_t;

    typedef logic [REPLY_LEN*8-1:0] frame_t;

    // Reply patterns, first byte in bits 7:0.
    localparam frame_t ROW_PAT [TABLE_ROWS] = '{
        72'hF9D0002000002008FF, 72'hF0D0202000004008FF, 72'hF8D0202010204008FF,
        72'hFAD0081081404008FF, 72'hFAD0002010004008FF, 72'hFAD0002800204008FF,
        72'hFAD0202810004008FF, 72'hF4D0281081004008FF, 72'hF8D0202010004008FF,
        72'hF8D0002800004008FF, 72'hF8D0082000004008FF, 72'hFAD0202000000008FF,
        72'hF8D0002000200008FF, 72'hFAD0200081000008FF, 72'hF8D0082010000008FF,
        72'hFAD0002000000008FF, 72'hF8D0082800000008FF, 72'hF4D0082000000008FF,
        72'hF8D0002010000008FF, 72'h17050403020100_08FF
    };
    localparam logic [4:0] ROW_MASK [TABLE_ROWS] = '{
        5'h01, 5'h03, 5'h0F, 5'h1F, 5'h07, 5'h0B, 5'h0D, 5'h19, 5'h05, 5'h09,
        5'h11, 5'h02, 5'h0A, 5'h04, 5'h14, 5'h08, 5'h18, 5'h10, 5'h00, 5'h00
    };
    localparam logic [TABLE_ROWS-1:0] ROW_KNOWN = 20'h3FFFF;

    // First matching row decides; unknown when no row matches.
    function automatic match_t lookup(input frame_t f);
        match_t m;
        logic   hit;
        m   = '0;
        hit = 1'b0;
        for (int i = 0; i < TABLE_ROWS; i++) begin
            if (!hit && f == ROW_PAT[i]) begin
                hit     = 1'b1;
                m.known = ROW_KNOWN[i];
                m.mask  = ROW_MASK[i];
            end
        end
        return m;
    endfunction

endpackage

// File: rtl/ztl_if.sv
// Valid/ready channel interface carrying one payload beat.
interface ztl_if #(parameter type payload_t = logic) (input logic clk);
    logic     valid;
    logic     ready;
    payload_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/ztl_core.sv
// Controller state and per-item result computation.
module ztl_core
    import ztl_pkg::*;
#(
    parameter int RING_DEPTH = 5
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [2:0]    cfg_index,
    input  logic [39:0]   cfg_data,
    input  logic          step,
    input  in_beat_t      item,
    input  match_t        match,
    output logic [7:0]    reply_start,
    output logic [3:0]    reply_count,
    output logic [1:0]    res_n,
    output out_beat_t     res [3]
);

    localparam int RW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CW = $clog2(RING_DEPTH + 1);

    typedef enum logic [1:0] {
        M_IDLE  = 2'd0,
        M_START = 2'd1,
        M_WAIT  = 2'd2
    } mode_t;

    logic [7:0]  prefix_reg, start_reg;
    logic [39:0] codes_reg;
    logic [4:0]  saved_reg, cur_reg, cur_next;
    logic [15:0] tmo_reg, ticks_reg, ticks_next;
    logic [3:0]  rlim_reg, retr_reg, retr_next, rcnt_reg, rcnt_next;
    mode_t       mode_reg, mode_next;
    logic [2:0]  ring_reg [RING_DEPTH];
    logic [2:0]  ring_next [RING_DEPTH];
    logic [RW-1:0] head_reg, head_next, tail_reg, tail_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [2:0]  act_reg, act_next;
    out_beat_t   r [3];
    logic [1:0]  n;

    assign reply_start = start_reg;
    assign reply_count = rcnt_reg;

    // Next-state and result logic for one item.
    always_comb
    begin
        logic [2:0] z;
        logic       frame_done;
        mode_next = mode_reg; cur_next = cur_reg; ticks_next = ticks_reg;
        retr_next = retr_reg; rcnt_next = rcnt_reg; head_next = head_reg;
        tail_next = tail_reg; cnt_next = cnt_reg; act_next = act_reg;
        ring_next = ring_reg;
        n = 2'd0;
        z = 3'd0;
        frame_done = 1'b0;
        for (int k = 0; k < 3; k++) r[k] = '0;
        case (item.command)
            CMD_START:
            begin
                cur_next = saved_reg;
                r[0].kind = KIND_MASK; r[0].active_zones = saved_reg;
                r[1].tx_byte = prefix_reg; r[2].tx_byte = codes_reg[7:0];
                n = 2'd3; mode_next = M_START; act_next = 3'd0; ticks_next = '0;
            end
            CMD_RX:
            begin
                if (rcnt_reg != 4'd0 || item.rx_byte == start_reg) begin
                    if (rcnt_reg == 4'(REPLY_LEN - 1)) begin
                        frame_done = 1'b1;
                        rcnt_next = '0;
                    end else begin
                        rcnt_next = rcnt_reg + 4'd1;
                    end
                end
            end
            CMD_ZONE:
            begin
                if (item.zone < 3'(ZONES)) begin
                    if (cur_reg[item.zone] == item.want_on) begin
                        r[0].kind = KIND_CONFIRM; r[0].confirm_zone = item.zone;
                        r[0].confirm_on = item.want_on; n = 2'd1;
                    end else if (cnt_reg < CW'(RING_DEPTH)) begin
                        ring_next[tail_reg] = item.zone;
                        tail_next = (tail_reg == RW'(RING_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                if (mode_reg != M_IDLE) begin
                    if (ticks_reg != 16'hFFFF) ticks_next = ticks_reg + 16'd1;
                    if (ticks_next >= tmo_reg) begin
                        if (retr_reg < rlim_reg) begin
                            retr_next = retr_reg + 4'd1;
                            r[0].tx_byte = prefix_reg;
                            r[1].tx_byte = codes_reg[8*act_reg +: 8];
                            n = 2'd2; ticks_next = '0;
                        end else begin
                            mode_next = M_IDLE; retr_next = '0;
                        end
                    end
                end
            end
        endcase

        // Completed reply frame.
        if (frame_done) begin
            if (mode_reg == M_START) begin
                retr_next = '0; mode_next = M_IDLE;
                r[0].kind = KIND_MASK; n = 2'd1;
                if (match.known) begin
                    cur_next = match.mask; r[0].active_zones = match.mask;
                    for (int i = 0; i < ZONES; i++) begin
                        if ((match.mask[i] ^ saved_reg[i]) && cnt_next < CW'(RING_DEPTH)) begin
                            ring_next[tail_next] = 3'(i);
                            tail_next = (tail_next == RW'(RING_DEPTH - 1)) ? '0
                                                                        : tail_next + 1'b1;
                            cnt_next = cnt_next + 1'b1;
                        end
                    end
                end else begin
                    cur_next = saved_reg; r[0].active_zones = saved_reg;
                end
            end else begin
                if (match.known) begin
                    cur_next = match.mask;
                    r[0].kind = KIND_MASK; r[0].active_zones = match.mask; n = 2'd1;
                end
                if (mode_reg == M_WAIT) begin
                    retr_next = '0; mode_next = M_IDLE;
                end
            end
        end

        // Dispatch the next queued toggle when the controller went idle.
        if (mode_next == M_IDLE && item.command != CMD_START
            && !(item.command == CMD_ZONE && mode_reg != M_IDLE)
            && !(item.command == CMD_RX && !(frame_done && mode_reg != M_IDLE))
            && !(item.command == CMD_TICK && mode_reg == M_IDLE)) begin
            if (cnt_next != '0) begin
                z = ring_next[head_next];
                head_next = (head_next == RW'(RING_DEPTH - 1)) ? '0 : head_next + 1'b1;
                cnt_next = cnt_next - 1'b1;
                mode_next = M_WAIT; retr_next = '0;
                if (z < 3'(ZONES)) begin
                    r[n].tx_byte = prefix_reg;
                    r[n + 2'd1].tx_byte = codes_reg[8*z +: 8];
                    n = n + 2'd2; act_next = z; ticks_next = '0;
                end
            end
        end
        if (n != 2'd0) r[n - 2'd1].last = 1'b1;
    end

    assign res_n = n;
    assign res = r;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            prefix_reg <= '0; codes_reg <= '0; start_reg <= 8'hFF;
            saved_reg <= '0; tmo_reg <= 16'd500; rlim_reg <= 4'd3;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_PREFIX:  prefix_reg <= cfg_data[7:0];
                REG_CODES:   codes_reg <= cfg_data;
                REG_START:   start_reg <= cfg_data[7:0];
                REG_SAVED:   saved_reg <= cfg_data[4:0];
                REG_TIMEOUT: tmo_reg <= cfg_data[15:0];
                REG_RETRY:   rlim_reg <= cfg_data[3:0];
                default:     ;
            endcase
        end
    end

    // Controller state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg <= M_IDLE; cur_reg <= '0; ticks_reg <= '0; retr_reg <= '0;
            rcnt_reg <= '0; head_reg <= '0; tail_reg <= '0; cnt_reg <= '0;
            act_reg <= '0;
        end else if (step) begin
            mode_reg <= mode_next; cur_reg <= cur_next; ticks_reg <= ticks_next;
            retr_reg <= retr_next; rcnt_reg <= rcnt_next; head_reg <= head_next;
            tail_reg <= tail_next; cnt_reg <= cnt_next; act_reg <= act_next;
        end
    end

    // Toggle ring storage.
    always_ff @(posedge clk)
    begin
        if (step) ring_reg <= ring_next;
    end

endmodule

// File: rtl/ztl_framer.sv
// Reply byte buffer and table match.
module ztl_framer
    import ztl_pkg::*;
(
    input  logic       clk,
    input  logic       capture,
    input  logic [3:0] index,
    input  logic [7:0] rx_byte,
    output match_t     match
);

    logic [7:0] buf_reg [REPLY_LEN-1];
    frame_t     frame;

    // Bytes one to eight are stored; the ninth comes straight from the input.
    always_ff @(posedge clk)
    begin
        if (capture && index < 4'(REPLY_LEN - 1)) buf_reg[index[2:0]] <= rx_byte;
    end

    always_comb
    begin
        for (int i = 0; i < REPLY_LEN - 1; i++) frame[8*i +: 8] = buf_reg[i];
        frame[8*(REPLY_LEN-1) +: 8] = rx_byte;
    end

    assign match = lookup(frame);

endmodule

// File: rtl/zone_toggle_link_controller.sv
// Top level of the zone toggle link controller.
// The block accepts one command beat on in_ch (start, received byte, zone
// request or tick) and produces up to three result beats on out_ch, the
// final one flagged by last. Configuration registers are written through
// cfg_we, cfg_index and cfg_data; the user must write them only while the
// block is idle; the block does not enforce this. An accepted beat is decoded
// combinationally; its results are loaded into a three-entry result
// register and leave one per cycle while the receiver is ready, so the
// first result appears in the cycle after acceptance. The next input beat
// is taken in the cycle the final result of the previous one is taken.
// Reset clears the controller state and loads register defaults; the reply
// buffer and toggle ring hold no reset value. When the receiver stalls,
// the pending result holds and input ready stays low until it drains.
module zone_toggle_link_controller
    import ztl_pkg::*;
#(
    parameter int RING_DEPTH = 5
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [39:0] cfg_data,
    ztl_if.sink         in_ch,
    ztl_if.source       out_ch
);

    out_beat_t  q_reg [3];
    logic [1:0] qn_reg, rd_reg;
    logic       step;
    logic [1:0] res_n;
    out_beat_t  res [3];
    match_t     match;
    logic [7:0] reply_start;
    logic [3:0] reply_count;
    in_beat_t   item;

    assign item = in_ch.payload;
    assign in_ch.ready = (qn_reg == 2'd0)
        || (out_ch.ready && rd_reg == qn_reg - 2'd1);
    assign step = in_ch.valid && in_ch.ready;

    ztl_framer u_framer (
        .clk     (clk),
        .capture (step && item.command == CMD_RX
                  && (reply_count != 4'd0 || item.rx_byte == reply_start)),
        .index   (reply_count),
        .rx_byte (item.rx_byte),
        .match   (match)
    );

    ztl_core #(.RING_DEPTH(RING_DEPTH)) u_core (
        .clk (clk), .rst_n (rst_n), .cfg_we (cfg_we), .cfg_index (cfg_index),
        .cfg_data (cfg_data), .step (step), .item (item), .match (match),
        .reply_start (reply_start), .reply_count (reply_count),
        .res_n (res_n), .res (res)
    );

    // Result queue: loaded per item, drained one beat per cycle on ready.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            qn_reg <= '0;
            rd_reg <= '0;
        end else if (step) begin
            qn_reg <= res_n;
            rd_reg <= '0;
        end else if (out_ch.valid && out_ch.ready) begin
            if (rd_reg == qn_reg - 2'd1) begin
                qn_reg <= '0;
                rd_reg <= '0;
            end else begin
                rd_reg <= rd_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step) q_reg <= res;
    end

    assign out_ch.valid = (qn_reg != 2'd0);
    assign out_ch.payload = q_reg[rd_reg];

    // The read pointer stays within the loaded results.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> rd_reg < qn_reg) else $error("read past results");
    // Only the final queued beat carries last.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (out_ch.payload.last == (rd_reg == qn_reg - 2'd1)))
        else $error("last misplaced");
    // Reply count never reaches the frame length.
    assert property (@(posedge clk) disable iff (!rst_n)
        reply_count < 4'(REPLY_LEN)) else $error("reply count overflow");

endmodule

// File: tb/sv/ztl_scoreboard.sv
// Checker that predicts the controller's result beats and compares them with the outputs.
module ztl_scoreboard
    import ztl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [39:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_ready,
    input  in_beat_t    in_beat,
    input  logic        out_valid,
    input  logic        out_ready,
    input  out_beat_t   out_beat,
    output int          errors,
    output int          pending,
    output int          results_seen,
    output int          known_replies,
    output int          confirms_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [1:0] {
        LINK_IDLE  = 2'd0,
        LINK_PROBE = 2'd1,
        LINK_WAIT  = 2'd2
    } link_mode_t;

    // Reply patterns (nine bytes), then the mask and whether the mask is known.
    localparam logic [7:0] ROWS [20][11] = '{
        '{8'hFF, 8'h08, 8'h20, 8'h00, 8'h00, 8'h20, 8'h00, 8'hD0, 8'hF9, 8'h01, 8'h1},
        '{8'hFF, 8'h08, 8'h40, 8'h00, 8'h00, 8'h20, 8'h20, 8'hD0, 8'hF0, 8'h03, 8'h1},
        '{8'hFF, 8'h08, 8'h40, 8'h20, 8'h10, 8'h20, 8'h20, 8'hD0, 8'hF8, 8'h0F, 8'h1},
        '{8'hFF, 8'h08, 8'h40, 8'h40, 8'h81, 8'h10, 8'h08, 8'hD0, 8'hFA, 8'h1F, 8'h1},
        '{8'hFF, 8'h08, 8'h40, 8'h00, 8'h10, 8'h20, 8'h00, 8'hD0, 8'hFA, 8'h07, 8'h1},
        '{8'hFF, 8'h08, 8'h40, 8'h20, 8'h00, 8'h28, 8'h00, 8'hD0, 8'hFA, 8'h0B, 8'h1},
        '{8'hFF, 8'h08, 8'h40, 8'h00, 8'h10, 8'h28, 8'h20, 8'hD0, 8'hFA, 8'h0D, 8'h1},
        '{8'hFF, 8'h08, 8'h40, 8'h00, 8'h81, 8'h10, 8'h28, 8'hD0, 8'hF4, 8'h19, 8'h1},
        '{8'hFF, 8'h08, 8'h40, 8'h00, 8'h10, 8'h20, 8'h20, 8'hD0, 8'hF8, 8'h05, 8'h1},
        '{8'hFF, 8'h08, 8'h40, 8'h00, 8'h00, 8'h28, 8'h00, 8'hD0, 8'hF8, 8'h09, 8'h1},
        '{8'hFF, 8'h08, 8'h40, 8'h00, 8'h00, 8'h20, 8'h08, 8'hD0, 8'hF8, 8'h11, 8'h1},
        '{8'hFF, 8'h08, 8'h00, 8'h00, 8'h00, 8'h20, 8'h20, 8'hD0, 8'hFA, 8'h02, 8'h1},
        '{8'hFF, 8'h08, 8'h00, 8'h20, 8'h00, 8'h20, 8'h00, 8'hD0, 8'hF8, 8'h0A, 8'h1},
        '{8'hFF, 8'h08, 8'h00, 8'h00, 8'h81, 8'h00, 8'h20, 8'hD0, 8'hFA, 8'h04, 8'h1},
        '{8'hFF, 8'h08, 8'h00, 8'h00, 8'h10, 8'h20, 8'h08, 8'hD0, 8'hF8, 8'h14, 8'h1},
        '{8'hFF, 8'h08, 8'h00, 8'h00, 8'h00, 8'h20, 8'h00, 8'hD0, 8'hFA, 8'h08, 8'h1},
        '{8'hFF, 8'h08, 8'h00, 8'h00, 8'h00, 8'h28, 8'h08, 8'hD0, 8'hF8, 8'h18, 8'h1},
        '{8'hFF, 8'h08, 8'h00, 8'h00, 8'h00, 8'h20, 8'h08, 8'hD0, 8'hF4, 8'h10, 8'h1},
        '{8'hFF, 8'h08, 8'h00, 8'h00, 8'h10, 8'h20, 8'h00, 8'hD0, 8'hF8, 8'h00, 8'h0},
        '{8'hFF, 8'h08, 8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h17, 8'h00, 8'h0}
    };

    // Configuration copy.
    logic [7:0]  prefix_byte;
    logic [39:0] code_bytes;
    logic [7:0]  frame_start;
    logic [4:0]  restore_mask;
    logic [15:0] timeout_ticks;
    logic [3:0]  retry_max;

    // Controller state copy.
    logic [7:0]  frame_bytes [9];
    int          frame_fill;
    link_mode_t  link_mode;
    logic [4:0]  zone_state;
    logic [2:0]  toggle_queue [5];
    int          q_head;
    int          q_tail;
    int          q_count;
    logic [2:0]  sending_zone;
    logic [3:0]  resends;
    logic [15:0] tick_count;

    out_beat_t   step_beats [$];
    out_beat_t   expected_beats [$];

    function automatic void add_beat(kind_t k, logic [7:0] tx, logic [4:0] m,
                                     logic [2:0] cz, logic con);
        out_beat_t b;
        b.kind         = k;
        b.tx_byte      = tx;
        b.active_zones = m;
        b.confirm_zone = cz;
        b.confirm_on   = con;
        b.last         = 1'b0;
        if (step_beats.size() < 3)
            step_beats.push_back(b);
    endfunction

    function automatic void publish_mask(logic [4:0] m);
        zone_state = m;
        add_beat(KIND_MASK, 8'h00, m, 3'd0, 1'b0);
    endfunction

    function automatic void transmit_toggle(logic [2:0] z);
        if (z < 3'd5) begin
            add_beat(KIND_TX, prefix_byte, 5'd0, 3'd0, 1'b0);
            add_beat(KIND_TX, code_bytes[8*z +: 8], 5'd0, 3'd0, 1'b0);
            sending_zone = z;
            tick_count   = 16'd0;
        end
    endfunction

    function automatic void queue_toggle(logic [2:0] z);
        if (q_count < 5) begin
            toggle_queue[q_tail] = z;
            q_tail  = (q_tail + 1) % 5;
            q_count = q_count + 1;
        end
    endfunction

    function automatic void send_next_toggle();
        logic [2:0] z;
        if (q_count == 0) begin
            link_mode = LINK_IDLE;
        end else begin
            z         = toggle_queue[q_head];
            q_head    = (q_head + 1) % 5;
            q_count   = q_count - 1;
            link_mode = LINK_WAIT;
            resends   = 4'd0;
            transmit_toggle(z);
        end
    endfunction

    // A complete reply frame: decode it against the table and act on the mode.
    function automatic void decode_reply();
        logic       known;
        logic       hit;
        logic       same;
        logic [4:0] m;
        known = 1'b0;
        hit   = 1'b0;
        m     = 5'd0;
        for (int r = 0; r < 20; r++) begin
            same = 1'b1;
            for (int k = 0; k < 9; k++)
                if (ROWS[r][k] != frame_bytes[k])
                    same = 1'b0;
            if (same && !hit) begin
                hit   = 1'b1;
                m     = ROWS[r][9][4:0];
                known = ROWS[r][10][0];
            end
        end
        if (known)
            known_replies++;
        if (link_mode == LINK_PROBE) begin
            resends   = 4'd0;
            link_mode = LINK_IDLE;
            if (known) begin
                publish_mask(m);
                for (int i = 0; i < 5; i++)
                    if (m[i] != restore_mask[i])
                        queue_toggle(3'(i));
            end else begin
                publish_mask(restore_mask);
            end
            send_next_toggle();
        end else begin
            if (known)
                publish_mask(m);
            if (link_mode == LINK_WAIT) begin
                resends   = 4'd0;
                link_mode = LINK_IDLE;
                send_next_toggle();
            end
        end
    endfunction

    // Work out the results of one accepted input beat.
    function automatic void predict_beat(in_beat_t b);
        step_beats.delete();
        case (cmd_t'(b.command))
            CMD_START: begin
                publish_mask(restore_mask);
                link_mode = LINK_PROBE;
                transmit_toggle(3'd0);
            end
            CMD_RX: begin
                if (frame_fill != 0 || b.rx_byte == frame_start) begin
                    frame_bytes[frame_fill] = b.rx_byte;
                    frame_fill++;
                    if (frame_fill >= 9) begin
                        decode_reply();
                        frame_fill = 0;
                    end
                end
            end
            CMD_ZONE: begin
                if (b.zone < 3'd5) begin
                    if (zone_state[b.zone] == b.want_on) begin
                        add_beat(KIND_CONFIRM, 8'h00, 5'd0, b.zone, b.want_on);
                    end else begin
                        queue_toggle(b.zone);
                        if (link_mode == LINK_IDLE)
                            send_next_toggle();
                    end
                end
            end
            default: begin
                if (link_mode != LINK_IDLE) begin
                    if (tick_count != 16'hFFFF)
                        tick_count++;
                    if (tick_count >= timeout_ticks) begin
                        if (resends < retry_max) begin
                            resends++;
                            transmit_toggle(sending_zone);
                        end else begin
                            link_mode = LINK_IDLE;
                            resends   = 4'd0;
                            send_next_toggle();
                        end
                    end
                end
            end
        endcase
        if (step_beats.size() > 0)
            step_beats[step_beats.size()-1].last = 1'b1;
        foreach (step_beats[i])
            expected_beats.push_back(step_beats[i]);
    endfunction

    // Sample configuration writes and both channels on each rising edge.
    always @(posedge clk or negedge rst_n) begin
        out_beat_t want;
        if (!rst_n) begin
            prefix_byte   = 8'h00;
            code_bytes    = 40'd0;
            frame_start   = 8'hFF;
            restore_mask  = 5'd0;
            timeout_ticks = 16'd500;
            retry_max     = 4'd3;
            frame_fill    = 0;
            link_mode     = LINK_IDLE;
            zone_state    = 5'd0;
            q_head        = 0;
            q_tail        = 0;
            q_count       = 0;
            sending_zone  = 3'd0;
            resends       = 4'd0;
            tick_count    = 16'd0;
            errors        = 0;
            results_seen  = 0;
            known_replies = 0;
            confirms_seen = 0;
            expected_beats.delete();
            pending       = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_PREFIX:  prefix_byte   = cfg_data[7:0];
                    REG_CODES:   code_bytes    = cfg_data;
                    REG_START:   frame_start   = cfg_data[7:0];
                    REG_SAVED:   restore_mask  = cfg_data[4:0];
                    REG_TIMEOUT: timeout_ticks = cfg_data[15:0];
                    REG_RETRY:   retry_max     = cfg_data[3:0];
                    default: ;
                endcase
            end
            if (out_valid && out_ready) begin
                results_seen++;
                if (out_beat.kind == KIND_CONFIRM)
                    confirms_seen++;
                if (expected_beats.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result beat: expected none, got %h",
                             $time, out_beat);
                end else begin
                    want = expected_beats.pop_front();
                    if (want.kind != out_beat.kind || want.tx_byte != out_beat.tx_byte ||
                        want.active_zones != out_beat.active_zones ||
                        want.confirm_zone != out_beat.confirm_zone ||
                        want.confirm_on != out_beat.confirm_on ||
                        want.last != out_beat.last) begin
                        errors++;
                        $display("%0t: result mismatch: expected %h, got %h",
                                 $time, want, out_beat);
                    end
                end
            end
            if (in_valid && in_ready)
                predict_beat(in_beat);
            pending = expected_beats.size();
        end
    end

endmodule

// File: tb/sv/tb.sv
// Top of the testbench: clock, reset, stimulus, receiver and the verdict.
module tb;
    import ztl_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [39:0] cfg_data;

    ztl_if #(.payload_t(in_beat_t))  in_ch  (clk);
    ztl_if #(.payload_t(out_beat_t)) out_ch (clk);

    int   errors;
    int   pending;
    int   results_seen;
    int   known_replies;
    int   confirms_seen;
    int   items_sent;
    int   cycle_count;
    bit   quiet;
    bit   stall_go;
    bit   stall_done;
    int   hold_left;
    logic [7:0] start_b;

    zone_toggle_link_controller u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    ztl_scoreboard u_chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_ch.valid),
        .in_ready      (in_ch.ready),
        .in_beat       (in_ch.payload),
        .out_valid     (out_ch.valid),
        .out_ready     (out_ch.ready),
        .out_beat      (out_ch.payload),
        .errors        (errors),
        .pending       (pending),
        .results_seen  (results_seen),
        .known_replies (known_replies),
        .confirms_seen (confirms_seen)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Idle length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Receiver: random stalls, plus one long hold-off while input keeps coming.
    always @(posedge clk) begin
        if (!rst_n) begin
            stall_done = 1'b0;
            hold_left  = 0;
            out_ch.ready <= 1'b0;
        end else if (stall_go && !stall_done) begin
            stall_done = 1'b1;
            hold_left  = 300;
            out_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end else begin
            hold_left = pick_gap();
            out_ch.ready <= (hold_left == 0);
        end
    end

    // Run limit.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > 400000) begin
            $display("zone_toggle_link_controller regression: fail");
            $finish;
        end
    end

    // Offer one beat and return at the edge that takes it.
    task automatic send_beat(cmd_t c, logic [7:0] rx, logic [2:0] z, logic w);
        in_beat_t b;
        int       gap;
        b.command = c;
        b.rx_byte = rx;
        b.zone    = z;
        b.want_on = w;
        gap = pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.payload <= b;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        items_sent++;
    endtask

    // Nine reply bytes: a table row, a row with one byte spoiled, or junk.
    task automatic send_frame(int row, int flavor);
        logic [7:0] v;
        int         bad;
        bad = $urandom_range(1, 8);
        for (int k = 0; k < 9; k++) begin
            v = ROW_PAT[row][8*k +: 8];
            if (k == 0)
                v = start_b;
            else if (flavor == 1 && k == bad)
                v = v ^ 8'($urandom_range(1, 255));
            else if (flavor == 2)
                v = 8'($urandom_range(0, 255));
            send_beat(CMD_RX, v, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
        end
    endtask

    // Wait until every expected beat is out, then let the block settle.
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [39:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    task automatic setup(logic [7:0] pre, logic [39:0] codes, logic [7:0] sb,
                         logic [4:0] sm, logic [15:0] tmo, logic [3:0] rl);
        write_reg(REG_PREFIX, {32'd0, pre});
        write_reg(REG_CODES, codes);
        write_reg(REG_START, {32'd0, sb});
        write_reg(REG_SAVED, {35'd0, sm});
        write_reg(REG_TIMEOUT, {24'd0, tmo});
        write_reg(REG_RETRY, {36'd0, rl});
        start_b = sb;
    endtask

    // Random traffic, mostly start/reply/request/tick sequences with some noise.
    task automatic random_traffic(int count);
        int stop_at;
        int r;
        stop_at = items_sent + count;
        send_beat(CMD_START, 8'h00, 3'd0, 1'b0);
        while (items_sent < stop_at) begin
            r = $urandom_range(0, 99);
            if (r < 30)
                send_frame($urandom_range(0, 19), ($urandom_range(0, 9) < 7) ? 0 :
                           $urandom_range(1, 2));
            else if (r < 60)
                send_beat(CMD_ZONE, 8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)),
                          1'($urandom_range(0, 1)));
            else if (r < 85)
                repeat ($urandom_range(1, 8))
                    send_beat(CMD_TICK, 8'($urandom_range(0, 255)),
                              3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
            else if (r < 90)
                send_beat(CMD_START, 8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)),
                          1'($urandom_range(0, 1)));
            else
                send_beat(cmd_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                          3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
        end
        drain();
    endtask

    initial begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = 3'd0;
        cfg_data      = 40'd0;
        in_ch.valid   = 1'b0;
        in_ch.payload = '0;
        quiet         = 1'b0;
        stall_go      = 1'b0;
        items_sent    = 0;
        start_b       = 8'hFF;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: probe, resend, give-up, known and unknown replies, requests.
        setup(8'hA5, 40'h8040201008, 8'hFF, 5'h15, 16'd2, 4'd1);
        send_beat(CMD_START, 8'h00, 3'd0, 1'b0);
        repeat (4) send_beat(CMD_TICK, 8'h00, 3'd0, 1'b0);
        send_frame(3, 0);
        send_beat(CMD_ZONE, 8'h00, 3'd0, 1'b1);
        send_beat(CMD_ZONE, 8'hFF, 3'd4, 1'b0);
        send_beat(CMD_RX, 8'h00, 3'd0, 1'b0);
        send_frame(19, 0);
        send_beat(CMD_ZONE, 8'h00, 3'd7, 1'b1);
        send_beat(CMD_START, 8'h00, 3'd0, 1'b0);
        send_frame(18, 0);
        drain();

        // Random phases over several settings, extremes included.
        setup(8'h00, 40'h0, 8'hFF, 5'h00, 16'd1, 4'd0);
        random_traffic(100);
        setup(8'hFF, 40'hFF_FFFF_FFFF, 8'hFF, 5'h1F, 16'd3, 4'd15);
        stall_go = 1'b1;
        quiet    = 1'b1;
        random_traffic(35);
        quiet    = 1'b0;
        random_traffic(70);
        setup(8'($urandom), {$urandom, 8'($urandom)}, 8'h00, 5'h0A, 16'hFFFF, 4'd2);
        random_traffic(95);
        setup(8'($urandom), {$urandom, 8'($urandom)}, 8'hFF, 5'($urandom),
              16'($urandom_range(1, 6)), 4'($urandom_range(0, 3)));
        random_traffic(105);

        $display("Sent %0d input beats; checked %0d result beats.", items_sent, results_seen);
        $display("Known replies decoded: %0d, state confirms: %0d.",
                 known_replies, confirms_seen);
        if (errors == 0)
            $display("zone_toggle_link_controller regression: pass");
        else
            $display("zone_toggle_link_controller regression: fail");
        $finish;
    end

endmodule

// File: sim.f
rtl/ztl_pkg.sv
rtl/ztl_if.sv
rtl/ztl_core.sv
rtl/ztl_framer.sv
rtl/zone_toggle_link_controller.sv
tb/sv/ztl_scoreboard.sv
tb/sv/tb.sv
